// ----- rtl/core/positional_insert_delete_array_macros.svh -----
// Assertion macros for the positional insert/delete array.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PIDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pida check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PIDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pida check failed");

`endif

// ----- rtl/core/pida_pkg.sv -----
package pida_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int IDX_W    = 5;
  localparam int WORD_W   = 32;

  localparam logic [2:0] OP_READ_AT     = 3'd0;
  localparam logic [2:0] OP_READ_LAST   = 3'd1;
  localparam logic [2:0] OP_REMOVE_AT   = 3'd2;
  localparam logic [2:0] OP_REMOVE_LAST = 3'd3;
  localparam logic [2:0] OP_INSERT_AT   = 3'd4;
  localparam logic [2:0] OP_APPEND      = 3'd5;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [2:0]               op;
    logic [IDX_W-1:0]         index;
    logic signed [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                     status;
    logic signed [WORD_W-1:0] read_value;
    logic [IDX_W-1:0]         length;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT
  } state_t;

endpackage

// ----- rtl/core/pida_ram.sv -----
module pida_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/positional_insert_delete_array.sv -----
// Densely packed array of CAPACITY signed 32-bit words with a fill count, held in one
// RAM with a registered read port. An item is taken when start is high and busy is low;
// its single result beat shows on out_item for one cycle with out_valid high, and the
// receiver cannot hold it off. Append, remove_last and every error give the result in
// the cycle after the item is taken and leave busy low; read_at and read_last keep busy
// high for one cycle. Remove_at and insert_at move m entries (m = length - index - 1 for
// remove, length - index for insert, length taken before the item) one per cycle through
// the RAM read and write ports, keeping busy high in ST_SHIFT until the last moved entry
// is written and, for insert_at, the new word is written at its index.
module positional_insert_delete_array (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  pida_pkg::in_t  in_item,
  output logic           out_valid,
  output pida_pkg::out_t out_item
);

  localparam int AW = pida_pkg::ADDR_W;
  localparam int IW = pida_pkg::IDX_W;
  localparam int WW = pida_pkg::WORD_W;

  pida_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]    fill_r, fill_nxt;
  logic [IW-1:0]    left_r, left_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    wa_r, wa_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic             ins_r, ins_nxt;
  logic [WW-1:0]    word_r, word_nxt;
  logic             out_valid_r, out_valid_nxt;
  pida_pkg::out_t   out_r, out_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  logic [WW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [WW-1:0] rdata;
  logic          accept;
  logic          full;
  logic          in_range;

  pida_ram #(
    .WIDTH (WW),
    .DEPTH (pida_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state_r != pida_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (fill_r == IW'(pida_pkg::CAPACITY));
  assign in_range  = (in_item.index < fill_r);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    left_nxt      = left_r;
    ptr_nxt       = ptr_r;
    wa_nxt        = wa_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    ins_nxt       = ins_r;
    word_nxt      = word_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;

    case (state_r)
      pida_pkg::ST_IDLE: begin
        if (accept) begin
          out_nxt.status     = pida_pkg::STATUS_ERR;
          out_nxt.read_value = '0;
          out_nxt.length     = fill_r;
          out_valid_nxt      = 1'b1;
          case (in_item.op)
            pida_pkg::OP_READ_AT: begin
              if (in_range) begin
                raddr         = in_item.index[AW-1:0];
                out_valid_nxt = 1'b0;
                state_nxt     = pida_pkg::ST_READ;
              end
            end
            pida_pkg::OP_READ_LAST: begin
              if (fill_r != '0) begin
                raddr         = AW'(fill_r - IW'(1));
                out_valid_nxt = 1'b0;
                state_nxt     = pida_pkg::ST_READ;
              end
            end
            pida_pkg::OP_REMOVE_AT: begin
              if (in_range) begin
                ins_nxt       = 1'b0;
                ptr_nxt       = AW'(in_item.index + IW'(1));
                left_nxt      = fill_r - in_item.index - IW'(1);
                pend_nxt      = 1'b0;
                fill_nxt      = fill_r - IW'(1);
                out_valid_nxt = 1'b0;
                state_nxt     = pida_pkg::ST_SHIFT;
              end
            end
            pida_pkg::OP_REMOVE_LAST: begin
              if (fill_r != '0) begin
                fill_nxt       = fill_r - IW'(1);
                out_nxt.status = pida_pkg::STATUS_OK;
                out_nxt.length = fill_r - IW'(1);
              end
            end
            pida_pkg::OP_INSERT_AT: begin
              if (!full && (in_item.index <= fill_r)) begin
                ins_nxt       = 1'b1;
                ptr_nxt       = AW'(fill_r - IW'(1));
                left_nxt      = fill_r - in_item.index;
                idx_nxt       = in_item.index[AW-1:0];
                word_nxt      = in_item.value;
                pend_nxt      = 1'b0;
                fill_nxt      = fill_r + IW'(1);
                out_valid_nxt = 1'b0;
                state_nxt     = pida_pkg::ST_SHIFT;
              end
            end
            pida_pkg::OP_APPEND: begin
              if (!full) begin
                we             = 1'b1;
                waddr          = fill_r[AW-1:0];
                wdata          = in_item.value;
                fill_nxt       = fill_r + IW'(1);
                out_nxt.status = pida_pkg::STATUS_OK;
                out_nxt.length = fill_r + IW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      pida_pkg::ST_READ: begin
        out_valid_nxt      = 1'b1;
        out_nxt.status     = pida_pkg::STATUS_OK;
        out_nxt.read_value = rdata;
        out_nxt.length     = fill_r;
        state_nxt          = pida_pkg::ST_IDLE;
      end

      pida_pkg::ST_SHIFT: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = wa_r;
          wdata = rdata;
        end
        if (left_r != '0) begin
          raddr    = ptr_r;
          pend_nxt = 1'b1;
          wa_nxt   = ins_r ? ptr_r + AW'(1) : ptr_r - AW'(1);
          ptr_nxt  = ins_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
          left_nxt = left_r - IW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (ins_r) begin
              we    = 1'b1;
              waddr = idx_r;
              wdata = word_r;
            end
            out_valid_nxt      = 1'b1;
            out_nxt.status     = pida_pkg::STATUS_OK;
            out_nxt.read_value = '0;
            out_nxt.length     = fill_r;
            state_nxt          = pida_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = pida_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pida_pkg::ST_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    ptr_r  <= ptr_nxt;
    wa_r   <= wa_nxt;
    idx_r  <= idx_nxt;
    ins_r  <= ins_nxt;
    word_r <= word_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ----- rtl/core/pida_checker.sv -----
`include "positional_insert_delete_array_macros.svh"

module pida_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input pida_pkg::in_t  in_item,
  input logic           out_valid,
  input pida_pkg::out_t out_item
);

  logic taken;
  logic quiet;

  assign taken = start && !busy;
  assign quiet = !start && !busy;

  `PIDA_ASSERT_NEXT(a_taken_progress, taken, busy || out_valid)
  `PIDA_ASSERT_NEXT(a_no_spurious_beat, quiet, !out_valid)
  `PIDA_ASSERT_NOW(a_error_zero_value, out_valid && out_item.status, out_item.read_value == '0)
  `PIDA_ASSERT_NOW(a_length_bound, out_valid, out_item.length <= 5'(pida_pkg::CAPACITY))

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (.*);
